>>> src/wmlm_pkg.sv
// Shared types and constants for the water meter leak monitor.
// Used by wmlm_cfg, water_meter_leak_monitor and the testbench; depends on nothing else.
package wmlm_pkg;

    // Item operation codes.
    localparam logic [1:0] OP_REPORT     = 2'd0;
    localparam logic [1:0] OP_TICK       = 2'd1;
    localparam logic [1:0] OP_SOFT_RESET = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SOFTENER_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_GAP         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_DURATION    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COOLDOWN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_COOLDOWN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_START      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_END        = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [31:0] RST_SOFTENER_LIMIT  = 32'd1500;
    localparam logic [31:0] RST_FLOW_GAP        = 32'd90000;
    localparam logic [31:0] RST_FLOW_DURATION   = 32'd1200000;
    localparam logic [31:0] RST_REPEAT_COOLDOWN = 32'd600000;
    localparam logic [31:0] RST_SOFT_COOLDOWN   = 32'd86400000;
    localparam logic [4:0]  RST_NIGHT_START     = 5'd1;
    localparam logic [4:0]  RST_NIGHT_END       = 5'd5;

    // Raw sender id of the first meter.
    localparam logic [7:0] FIRST_METER_ID = 8'd2;

    typedef struct packed {
        logic [31:0] softener_limit;
        logic [31:0] flow_gap_ms;
        logic [31:0] flow_duration_ms;
        logic [31:0] repeat_cooldown_ms;
        logic [31:0] softener_cooldown_ms;
        logic [4:0]  night_start_hour;
        logic [4:0]  night_end_hour;
    } cfg_t;

endpackage

>>> src/wmlm_cfg.sv
// Configuration register file of the water meter leak monitor.
// Depends on wmlm_pkg for the register indexes, reset values and cfg_t.
module wmlm_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [wmlm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    output wmlm_pkg::cfg_t                  cfg
);
    import wmlm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.softener_limit       <= RST_SOFTENER_LIMIT;
            cfg_reg.flow_gap_ms          <= RST_FLOW_GAP;
            cfg_reg.flow_duration_ms     <= RST_FLOW_DURATION;
            cfg_reg.repeat_cooldown_ms   <= RST_REPEAT_COOLDOWN;
            cfg_reg.softener_cooldown_ms <= RST_SOFT_COOLDOWN;
            cfg_reg.night_start_hour     <= RST_NIGHT_START;
            cfg_reg.night_end_hour       <= RST_NIGHT_END;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SOFTENER_LIMIT:  cfg_reg.softener_limit       <= cfg_data;
                REG_FLOW_GAP:        cfg_reg.flow_gap_ms          <= cfg_data;
                REG_FLOW_DURATION:   cfg_reg.flow_duration_ms     <= cfg_data;
                REG_REPEAT_COOLDOWN: cfg_reg.repeat_cooldown_ms   <= cfg_data;
                REG_SOFT_COOLDOWN:   cfg_reg.softener_cooldown_ms <= cfg_data;
                REG_NIGHT_START:     cfg_reg.night_start_hour     <= cfg_data[4:0];
                REG_NIGHT_END:       cfg_reg.night_end_hour       <= cfg_data[4:0];
                default:             ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/water_meter_leak_monitor.sv
// Water meter leak monitor: meter totals, softener tracking and flow alarms.
// Depends on wmlm_pkg and wmlm_cfg.
// Each item passes through the input register, then the result register, before its
// result is valid. Throughput: one item per cycle while out_stall does not hold the
// result register, set by the combinational state update between the two registers.
// Reset clears all totals, flags and timestamps and loads the default configuration.
module water_meter_leak_monitor #(
    parameter int NUM_METERS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wmlm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    // input items
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      operation,
    input  logic [31:0]                     now_ms,
    input  logic [7:0]                      meter_id,
    input  logic [31:0]                     pulses,
    input  logic [4:0]                      hour_of_day,
    input  logic                            time_valid,
    // results
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            report_accepted,
    output logic [1:0]                      meter_index,
    output logic [31:0]                     meter_total,
    output logic                            night_alarm,
    output logic                            continuous_alarm,
    output logic                            softener_reminder,
    output logic                            softener_alarm_active
);
    import wmlm_pkg::*;

    localparam int IDX_W = (NUM_METERS > 1) ? $clog2(NUM_METERS) : 1;

    cfg_t cfg;

    wmlm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign cfg_ready = 1'b1;

    // Input register.
    logic        s1_valid_reg;
    logic [1:0]  s1_op_reg;
    logic [31:0] s1_now_reg;
    logic [7:0]  s1_id_reg;
    logic [31:0] s1_pulses_reg;
    logic [4:0]  s1_hour_reg;
    logic        s1_tvalid_reg;

    // Result register.
    logic        res_valid_reg;
    logic        res_acc_reg;
    logic [1:0]  res_midx_reg;
    logic [31:0] res_mtot_reg;
    logic        res_night_reg;
    logic        res_cont_reg;
    logic        res_remind_reg;
    logic        res_salarm_reg;

    // Monitor state.
    logic [31:0] tot_reg [NUM_METERS];
    logic [31:0] soft_used_reg, soft_used_next;
    logic        soft_alarm_reg, soft_alarm_next;
    logic        flow_active_reg, flow_active_next;
    logic [31:0] flow_start_reg, flow_start_next;
    logic [31:0] flow_last_reg, flow_last_next;
    logic        cont_sent_reg, cont_sent_next;
    logic [31:0] cont_time_reg, cont_time_next;
    logic        night_sent_reg, night_sent_next;
    logic [31:0] night_time_reg, night_time_next;
    logic        rem_sent_reg, rem_sent_next;
    logic [31:0] rem_time_reg, rem_time_next;

    // Combinational results of the item in the input register.
    logic             advance;
    logic             fire;
    logic [7:0]       id_off;
    logic             id_ok;
    logic [IDX_W-1:0] idx;
    logic             tot_we;
    logic [31:0]      tot_wdata;
    logic             clr_soft_total;
    logic             acc_c;
    logic [31:0]      mtot_c;
    logic             night_c;
    logic             cont_c;
    logic             remind_c;

    // The result register frees whenever it is empty or its result transfers.
    assign advance  = !res_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    assign id_off = s1_id_reg - FIRST_METER_ID;
    assign id_ok  = (s1_id_reg >= FIRST_METER_ID) && (id_off < 8'(NUM_METERS));
    assign idx    = id_off[IDX_W-1:0];

    always_comb
    begin
        logic [31:0] sum;
        logic [31:0] soft_sum;
        logic        has_pulses;
        logic        in_night;
        logic        night_cool;
        logic        cont_cool;
        logic        rem_cool;

        sum        = tot_reg[idx] + s1_pulses_reg;
        soft_sum   = soft_used_reg + s1_pulses_reg;
        has_pulses = s1_pulses_reg != 32'd0;
        in_night   = (s1_hour_reg >= cfg.night_start_hour)
                     && (s1_hour_reg < cfg.night_end_hour);
        night_cool = !night_sent_reg
                     || ((s1_now_reg - night_time_reg) >= cfg.repeat_cooldown_ms);
        cont_cool  = !cont_sent_reg
                     || ((s1_now_reg - cont_time_reg) >= cfg.repeat_cooldown_ms);
        rem_cool   = !rem_sent_reg
                     || ((s1_now_reg - rem_time_reg) >= cfg.softener_cooldown_ms);

        soft_used_next   = soft_used_reg;
        soft_alarm_next  = soft_alarm_reg;
        flow_active_next = flow_active_reg;
        flow_start_next  = flow_start_reg;
        flow_last_next   = flow_last_reg;
        cont_sent_next   = cont_sent_reg;
        cont_time_next   = cont_time_reg;
        night_sent_next  = night_sent_reg;
        night_time_next  = night_time_reg;
        rem_sent_next    = rem_sent_reg;
        rem_time_next    = rem_time_reg;
        tot_we           = 1'b0;
        tot_wdata        = sum;
        clr_soft_total   = 1'b0;
        acc_c            = 1'b0;
        mtot_c           = 32'd0;
        night_c          = 1'b0;
        cont_c           = 1'b0;
        remind_c         = 1'b0;

        case (s1_op_reg)
            OP_REPORT:
            begin
                if (id_ok)
                begin
                    acc_c  = 1'b1;
                    tot_we = 1'b1;
                    if (idx == IDX_W'(0) && has_pulses)
                    begin
                        if (!flow_active_reg)
                        begin
                            flow_active_next = 1'b1;
                            flow_start_next  = s1_now_reg;
                        end
                        flow_last_next = s1_now_reg;
                    end
                    // The softener meter total follows the consumption value.
                    if (idx == IDX_W'(1) && has_pulses)
                    begin
                        soft_used_next = soft_sum;
                        tot_wdata      = soft_sum;
                        if (!soft_alarm_reg && soft_sum >= cfg.softener_limit)
                        begin
                            soft_alarm_next = 1'b1;
                        end
                    end
                    if (has_pulses && s1_tvalid_reg && in_night && night_cool)
                    begin
                        night_c         = 1'b1;
                        night_sent_next = 1'b1;
                        night_time_next = s1_now_reg;
                    end
                    mtot_c = tot_wdata;
                end
            end
            OP_TICK:
            begin
                if (flow_active_reg)
                begin
                    if ((s1_now_reg - flow_last_reg) > cfg.flow_gap_ms)
                    begin
                        flow_active_next = 1'b0;
                        flow_start_next  = 32'd0;
                        flow_last_next   = 32'd0;
                    end
                    else if ((s1_now_reg - flow_start_reg) >= cfg.flow_duration_ms
                             && cont_cool)
                    begin
                        cont_c         = 1'b1;
                        cont_sent_next = 1'b1;
                        cont_time_next = s1_now_reg;
                    end
                end
                if (soft_alarm_reg && rem_cool)
                begin
                    remind_c      = 1'b1;
                    rem_sent_next = 1'b1;
                    rem_time_next = s1_now_reg;
                end
            end
            OP_SOFT_RESET:
            begin
                soft_used_next  = 32'd0;
                soft_alarm_next = 1'b0;
                rem_sent_next   = 1'b0;
                rem_time_next   = 32'd0;
                clr_soft_total  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_op_reg     <= operation;
            s1_now_reg    <= now_ms;
            s1_id_reg     <= meter_id;
            s1_pulses_reg <= pulses;
            s1_hour_reg   <= hour_of_day;
            s1_tvalid_reg <= time_valid;
        end
        if (fire)
        begin
            res_acc_reg    <= acc_c;
            res_midx_reg   <= acc_c ? id_off[1:0] : 2'd0;
            res_mtot_reg   <= mtot_c;
            res_night_reg  <= night_c;
            res_cont_reg   <= cont_c;
            res_remind_reg <= remind_c;
            res_salarm_reg <= soft_alarm_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_METERS; i++)
            begin
                tot_reg[i] <= 32'd0;
            end
            soft_used_reg   <= 32'd0;
            soft_alarm_reg  <= 1'b0;
            flow_active_reg <= 1'b0;
            flow_start_reg  <= 32'd0;
            flow_last_reg   <= 32'd0;
            cont_sent_reg   <= 1'b0;
            cont_time_reg   <= 32'd0;
            night_sent_reg  <= 1'b0;
            night_time_reg  <= 32'd0;
            rem_sent_reg    <= 1'b0;
            rem_time_reg    <= 32'd0;
        end
        else if (fire)
        begin
            for (int i = 0; i < NUM_METERS; i++)
            begin
                if (tot_we && idx == IDX_W'(i))
                begin
                    tot_reg[i] <= tot_wdata;
                end
                else if (clr_soft_total && i == 1)
                begin
                    tot_reg[i] <= 32'd0;
                end
            end
            soft_used_reg   <= soft_used_next;
            soft_alarm_reg  <= soft_alarm_next;
            flow_active_reg <= flow_active_next;
            flow_start_reg  <= flow_start_next;
            flow_last_reg   <= flow_last_next;
            cont_sent_reg   <= cont_sent_next;
            cont_time_reg   <= cont_time_next;
            night_sent_reg  <= night_sent_next;
            night_time_reg  <= night_time_next;
            rem_sent_reg    <= rem_sent_next;
            rem_time_reg    <= rem_time_next;
        end
    end

    assign out_valid             = res_valid_reg;
    assign report_accepted       = res_acc_reg;
    assign meter_index           = res_midx_reg;
    assign meter_total           = res_mtot_reg;
    assign night_alarm           = res_night_reg;
    assign continuous_alarm      = res_cont_reg;
    assign softener_reminder     = res_remind_reg;
    assign softener_alarm_active = res_salarm_reg;

endmodule

>>> sim/tb.sv
// Self-checking testbench for water_meter_leak_monitor: a directed table, then
// phased random traffic under several register settings, checked by a local predictor.
// Depends on wmlm_pkg and the water_meter_leak_monitor RTL.
module tb;
    import wmlm_pkg::*;

    localparam int NUM_METERS     = 3;
    localparam int NUM_REGS       = REG_NIGHT_END + 1;
    localparam int NUM_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int SQUEEZE_PHASE  = 1;
    localparam int WRAP_PHASE     = 4;
    localparam int QUIET_PHASE    = 5;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now;
        logic [7:0]  id;
        logic [31:0] pulses;
        logic [4:0]  hour;
        logic        tvalid;
    } meter_item_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  index;
        logic [31:0] total;
        logic        night;
        logic        cont;
        logic        remind;
        logic        soft_alarm;
    } leak_result_t;

    typedef struct packed {
        meter_item_t  item;
        logic         typed;
        leak_result_t want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           operation;
    logic [31:0]          now_ms;
    logic [7:0]           meter_id;
    logic [31:0]          pulses;
    logic [4:0]           hour_of_day;
    logic                 time_valid;
    logic                 out_valid;
    logic                 out_stall;
    logic                 report_accepted;
    logic [1:0]           meter_index;
    logic [31:0]          meter_total;
    logic                 night_alarm;
    logic                 continuous_alarm;
    logic                 softener_reminder;
    logic                 softener_alarm_active;

    water_meter_leak_monitor #(.NUM_METERS(NUM_METERS)) dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor copy of the block state and its registers.
    cfg_t        cfg_cur = '{RST_SOFTENER_LIMIT, RST_FLOW_GAP, RST_FLOW_DURATION,
                             RST_REPEAT_COOLDOWN, RST_SOFT_COOLDOWN, RST_NIGHT_START,
                             RST_NIGHT_END};
    logic [31:0] meter_sum [NUM_METERS] = '{default: '0};
    logic [31:0] soft_used   = '0;
    logic        soft_alarm  = 1'b0;
    logic        run_active  = 1'b0;
    logic [31:0] run_start   = '0;
    logic [31:0] run_last    = '0;
    logic        cont_sent   = 1'b0;
    logic [31:0] cont_when   = '0;
    logic        night_sent  = 1'b0;
    logic [31:0] night_when  = '0;
    logic        remind_sent = 1'b0;
    logic [31:0] remind_when = '0;

    leak_result_t pending_results [$];
    dir_row_t     dir_rows [$];
    leak_result_t got_res;
    leak_result_t want_res;
    int           mismatches   = 0;
    int           stuck_cycles = 0;
    logic [31:0]  time_cursor  = '0;
    bit           squeeze_req  = 1'b0;
    bit           quiet        = 1'b0;

    // Columns follow the register index order.
    logic [31:0] phase_cfg [NUM_PHASES][NUM_REGS] = '{
        '{32'd1500, 32'd90000, 32'd1200000, 32'd600000, 32'd86400000, 32'd1, 32'd5},
        '{32'd40, 32'd800, 32'd4000, 32'd2500, 32'd9000, 32'd0, 32'd24},
        '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          32'd23, 32'd24},
        '{32'd300, 32'd5000, 32'd30000, 32'd20000, 32'd100000, 32'd20, 32'd4},
        '{32'd1, 32'd2000, 32'd10000, 32'd5000, 32'd15000, 32'd16, 32'd23}
    };
    logic [31:0] step_max [NUM_PHASES] = '{32'd40000, 32'd500, 32'd2, 32'hFFFFFFFF,
                                           32'd3000, 32'd1000};

    function automatic leak_result_t predict_step(input meter_item_t it);
        leak_result_t r;
        int           idx;
        logic         in_night;
        logic         cool;
        r = '0;
        case (it.op)
            OP_REPORT:
            begin
                if (it.id >= FIRST_METER_ID && (it.id - FIRST_METER_ID) < NUM_METERS)
                begin
                    idx = it.id - FIRST_METER_ID;
                    meter_sum[idx] = meter_sum[idx] + it.pulses;
                    if (idx == 0 && it.pulses != 0)
                    begin
                        if (!run_active)
                        begin
                            run_active = 1'b1;
                            run_start  = it.now;
                        end
                        run_last = it.now;
                    end
                    if (idx == 1 && it.pulses != 0)
                    begin
                        soft_used    = soft_used + it.pulses;
                        meter_sum[1] = soft_used;
                        if (!soft_alarm && soft_used >= cfg_cur.softener_limit)
                            soft_alarm = 1'b1;
                    end
                    if (it.pulses != 0 && it.tvalid)
                    begin
                        in_night = it.hour >= cfg_cur.night_start_hour &&
                                   it.hour < cfg_cur.night_end_hour;
                        cool = !night_sent ||
                               (it.now - night_when) >= cfg_cur.repeat_cooldown_ms;
                        if (in_night && cool)
                        begin
                            r.night    = 1'b1;
                            night_sent = 1'b1;
                            night_when = it.now;
                        end
                    end
                    r.accepted = 1'b1;
                    r.index    = idx[1:0];
                    r.total    = meter_sum[idx];
                end
            end
            OP_TICK:
            begin
                if (run_active)
                begin
                    // A long enough gap closes the run before any duration check.
                    if ((it.now - run_last) > cfg_cur.flow_gap_ms)
                    begin
                        run_active = 1'b0;
                        run_start  = '0;
                        run_last   = '0;
                    end
                    else if ((it.now - run_start) >= cfg_cur.flow_duration_ms)
                    begin
                        if (!cont_sent || (it.now - cont_when) >= cfg_cur.repeat_cooldown_ms)
                        begin
                            r.cont    = 1'b1;
                            cont_sent = 1'b1;
                            cont_when = it.now;
                        end
                    end
                end
                if (soft_alarm)
                begin
                    if (!remind_sent ||
                        (it.now - remind_when) >= cfg_cur.softener_cooldown_ms)
                    begin
                        r.remind    = 1'b1;
                        remind_sent = 1'b1;
                        remind_when = it.now;
                    end
                end
            end
            OP_SOFT_RESET:
            begin
                soft_used    = '0;
                soft_alarm   = 1'b0;
                remind_sent  = 1'b0;
                remind_when  = '0;
                meter_sum[1] = '0;
            end
            default: ;
        endcase
        r.soft_alarm = soft_alarm;
        return r;
    endfunction

    function automatic dir_row_t dir_row(input logic [1:0] op, input logic [31:0] now,
                                         input logic [7:0] id, input logic [31:0] p,
                                         input logic [4:0] h, input logic tv,
                                         input logic typed, input logic acc,
                                         input logic [1:0] mi, input logic [31:0] tot,
                                         input logic na, input logic ca, input logic sr,
                                         input logic sa);
        dir_row_t d;
        d.item  = '{op, now, id, p, h, tv};
        d.typed = typed;
        d.want  = '{acc, mi, tot, na, ca, sr, sa};
        return d;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic meter_item_t rand_item(input int ph);
        meter_item_t it;
        int          pick;
        it.hour   = 5'($urandom_range(0, 23));
        it.tvalid = ($urandom_range(0, 99) < 85);
        it.id     = 8'($urandom);
        it.pulses = $urandom;
        pick      = $urandom_range(0, 99);
        if (pick < 10)
        begin
            // Any two-bit operation, the unused code included.
            it.op  = 2'($urandom);
            it.now = $urandom;
            return it;
        end
        if ($urandom_range(0, 49) == 0)
            time_cursor = time_cursor + $urandom;
        else
            time_cursor = time_cursor + $urandom_range(0, step_max[ph]);
        it.now = time_cursor;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            it.pulses = '0;
        else if (pick < 80)
            it.pulses = $urandom_range(1, 20);
        it.op = OP_REPORT;
        pick  = $urandom_range(0, 99);
        if (pick < 40)
            it.id = FIRST_METER_ID;
        else if (pick < 55)
            it.id = FIRST_METER_ID + 8'd1;
        else if (pick < 63)
            it.id = FIRST_METER_ID + 8'd2;
        else if (pick < 70)
        begin
            while (it.id >= FIRST_METER_ID && it.id < FIRST_METER_ID + NUM_METERS)
                it.id = 8'($urandom);
        end
        else if (pick < 96)
            it.op = OP_TICK;
        else
            it.op = OP_SOFT_RESET;
        return it;
    endfunction

    // Leaves the register valid high so back-to-back writes need one assignment per step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_SOFTENER_LIMIT:  cfg_cur.softener_limit       = val;
            REG_FLOW_GAP:        cfg_cur.flow_gap_ms          = val;
            REG_FLOW_DURATION:   cfg_cur.flow_duration_ms     = val;
            REG_REPEAT_COOLDOWN: cfg_cur.repeat_cooldown_ms   = val;
            REG_SOFT_COOLDOWN:   cfg_cur.softener_cooldown_ms = val;
            REG_NIGHT_START:     cfg_cur.night_start_hour     = val[4:0];
            REG_NIGHT_END:       cfg_cur.night_end_hour       = val[4:0];
            default: ;
        endcase
    endtask

    task automatic send_item(input meter_item_t it, input logic typed,
                             input leak_result_t typed_want);
        int           gap;
        leak_result_t calc;
        gap = (squeeze_req || quiet) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operation   <= it.op;
        now_ms      <= it.now;
        meter_id    <= it.id;
        pulses      <= it.pulses;
        hour_of_day <= it.hour;
        time_valid  <= it.tvalid;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        calc = predict_step(it);
        pending_results.push_back(typed ? typed_want : calc);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        operation   <= OP_TICK;
        now_ms      <= '0;
        meter_id    <= '0;
        pulses      <= '0;
        hour_of_day <= '0;
        time_valid  <= 1'b0;

        dir_rows.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_SOFT_RESET, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        // Unknown ids on both sides of the meter range are ignored.
        dir_rows.push_back(dir_row(OP_REPORT, 0, 0, 32'hFFFFFFFF, 2, 1,
                                   1, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_REPORT, 0, 255, 32'hFFFFFFFF, 2, 1,
                                   1, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_REPORT, 0, 5, 5, 2, 1, 1, 0, 0, 0, 0, 0, 0, 0));
        // Zero pulses inside the night window raise nothing.
        dir_rows.push_back(dir_row(OP_REPORT, 0, 2, 0, 2, 1, 1, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_REPORT, 1000, 4, 32'hFFFFFFFF, 23, 1,
                                   1, 1, 2, 32'hFFFFFFFF, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_REPORT, 2000, 4, 1, 0, 1, 1, 1, 2, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_REPORT, 10000, 2, 10, 1, 1, 1, 1, 0, 10, 1, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_REPORT, 20000, 2, 5, 4, 1, 1, 1, 0, 15, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_REPORT, 700000, 2, 1, 5, 1, 1, 1, 0, 16, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_TICK, 790000, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_REPORT, 1200000, 2, 1, 3, 0,
                                   1, 1, 0, 17, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_TICK, 1210000, 0, 0, 0, 1, 1, 0, 0, 0, 0, 1, 0, 0));
        dir_rows.push_back(dir_row(OP_TICK, 1250000, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_TICK, 1290001, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_REPORT, 1300000, 3, 1499, 12, 1,
                                   1, 1, 1, 1499, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_REPORT, 1300001, 3, 1, 12, 1,
                                   1, 1, 1, 1500, 0, 0, 0, 1));
        dir_rows.push_back(dir_row(OP_TICK, 1400000, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 1, 1));
        dir_rows.push_back(dir_row(OP_TICK, 87799999, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 1));
        dir_rows.push_back(dir_row(OP_TICK, 87800000, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 1, 1));
        dir_rows.push_back(dir_row(OP_REPORT, 87800001, 3, 0, 12, 1,
                                   1, 1, 1, 1500, 0, 0, 0, 1));
        dir_rows.push_back(dir_row(OP_SOFT_RESET, 87800002, 0, 0, 0, 1,
                                   1, 0, 0, 0, 0, 0, 0, 0));
        // Times straddling the 32-bit wrap.
        dir_rows.push_back(dir_row(OP_REPORT, 32'hFFFFFFF0, 3, 7, 2, 1,
                                   0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_REPORT, 32'h00000100, 2, 3, 2, 1,
                                   0, 0, 0, 0, 0, 0, 0, 0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            for (int r = 0; r < NUM_REGS; r++)
                write_reg(r[CFG_IDX_W-1:0], phase_cfg[ph][r]);
            cfg_valid <= 1'b0;
            if (ph == WRAP_PHASE)
                time_cursor = 32'hFFFF0000;
            quiet       = (ph == QUIET_PHASE);
            squeeze_req = (ph == SQUEEZE_PHASE);
            repeat (ITEMS_PER_PHASE)
                send_item(rand_item(ph), 1'b0, '0);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver side: random stalls, one long hold-off while the sender keeps offering.
    initial
    begin : stall_gen
        int n;
        bit squeezed;
        squeezed  = 1'b0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (squeeze_req && !squeezed)
            begin
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeezed = 1'b1;
            end
            else
            begin
                n = quiet ? 0 : pick_gap();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_res = '{report_accepted, meter_index, meter_total, night_alarm,
                        continuous_alarm, softener_reminder, softener_alarm_active};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected result transfer: actual %0h", $time, got_res);
            end
            else
            begin
                want_res = pending_results.pop_front();
                check_field("report_accepted", want_res.accepted, got_res.accepted);
                check_field("meter_index", want_res.index, got_res.index);
                check_field("meter_total", want_res.total, got_res.total);
                check_field("night_alarm", want_res.night, got_res.night);
                check_field("continuous_alarm", want_res.cont, got_res.cont);
                check_field("softener_reminder", want_res.remind, got_res.remind);
                check_field("softener_alarm_active", want_res.soft_alarm,
                            got_res.soft_alarm);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

>>> filelist.f
src/wmlm_pkg.sv
src/wmlm_cfg.sv
src/water_meter_leak_monitor.sv
sim/tb.sv
